@@ design/mimf_pkg.sv @@
// Shared types and constants for the masked-input Mealy machine.
// No dependencies; imported by every module of the block.
package mimf_pkg;

	localparam int NUM_STATES    = 16;
	localparam int NUM_INPUTS    = 8;
	localparam int TABLE_COLUMNS = 4;
	localparam int ACTION_BITS   = 2;

	localparam int STATE_W = $clog2(NUM_STATES);
	localparam int ADDR_W  = STATE_W + TABLE_COLUMNS;
	localparam int CNT_W   = $clog2(NUM_INPUTS + 1);

	// APB register map (byte addresses)
	localparam int       PADDR_W          = 3;
	localparam logic [PADDR_W-1:0] ADDR_START_STATE = 3'h0;

	typedef logic [STATE_W-1:0]       state_t;
	typedef logic [TABLE_COLUMNS-1:0] tbl_idx_t;
	typedef logic [ACTION_BITS-1:0]   action_t;
	typedef logic [NUM_INPUTS-1:0]    inputs_t;

	typedef enum logic [1:0] {
		MODE_STEP    = 2'd0,
		MODE_RESTART = 2'd1,
		MODE_MASK    = 2'd2,
		MODE_ENTRY   = 2'd3
	} mode_t;

	typedef struct packed {
		action_t act;
		state_t  next;
	} entry_t;

	typedef struct packed {
		logic    req;
		state_t  target;
		inputs_t mask;
	} mask_wr_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} tbl_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} tbl_rd_t;

endpackage

@@ design/mimf_apb_regs.sv @@
// APB configuration register: start state.
// Depends on mimf_pkg.
module mimf_apb_regs
	import mimf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output state_t             start_state
);

	logic   wr_en;
	state_t start_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready & (paddr == ADDR_START_STATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (wr_en) begin
			start_q <= pwdata[STATE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_START_STATE) begin
			prdata[STATE_W-1:0] = start_q;
		end
	end

	assign start_state = start_q;

endmodule

@@ design/mimf_mask_gather.sv @@
// Per-state input masks and the gather that packs selected sense bits
// into a table index. Depends on mimf_pkg.
module mimf_mask_gather
	import mimf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mask_wr_t mask_wr,
	output logic     refuse,
	input  state_t   rd_state,
	input  inputs_t  sense,
	output tbl_idx_t idx
);

	localparam int IDX_W = (TABLE_COLUMNS > 1) ? $clog2(TABLE_COLUMNS) : 1;

	inputs_t              mask_q [NUM_STATES];
	logic [CNT_W-1:0]     wr_ones;
	inputs_t              rd_mask;
	logic [CNT_W-1:0]     pos;

	always_comb begin
		wr_ones = '0;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			wr_ones = wr_ones + CNT_W'(mask_wr.mask[i]);
		end
	end

	assign refuse = (wr_ones > CNT_W'(TABLE_COLUMNS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_STATES; s++) begin
				mask_q[s] <= '0;
			end
		end else if (mask_wr.req && !refuse) begin
			mask_q[mask_wr.target] <= mask_wr.mask;
		end
	end

	assign rd_mask = mask_q[rd_state];

	// selected inputs fill index bits from the bottom; refused masks never
	// reach the store, so pos stays within the table width
	always_comb begin
		pos = '0;
		idx = '0;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			if (rd_mask[i]) begin
				if (pos < CNT_W'(TABLE_COLUMNS) && sense[i]) begin
					idx[pos[IDX_W-1:0]] = 1'b1;
				end
				pos = pos + CNT_W'(1);
			end
		end
	end

endmodule

@@ design/mimf_table_ram.sv @@
// Transition table memory: one write port, one read port, registered read.
// Depends on mimf_pkg.
module mimf_table_ram
	import mimf_pkg::*;
(
	input  logic    clk,
	input  tbl_wr_t wr,
	input  tbl_rd_t rd,
	output entry_t  rd_data
);

	entry_t mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.re) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

@@ design/masked_input_mealy_fsm_top.sv @@
// Masked-input Mealy machine: one item accepted per clock while the output is not stalled.
// Depends on mimf_pkg, mimf_apb_regs, mimf_mask_gather and mimf_table_ram.
//
// Takes one item every cycle, including back-to-back steps, while the output
// is not stalled. The accept edge starts the synchronous table read, addressed
// by the current state (forwarded from the item in stage 1 if there is one)
// and the gathered index; stage 1 resolves the next state from the read data,
// and the output register holds the result until taken. tvalid rises when the
// item moves from stage 1 into the output register. While a result waits in
// the output register, stage 1 holds and the input stalls once stage 1 is
// occupied. The tightest path is table read data -> mask select -> gather ->
// table address. Masks reset to empty; table entries must be written before a
// step reads them.
module masked_input_mealy_fsm_top
	import mimf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// [7:0] sense_bits, [11:8] target_state, [19:12] mask_value,
	// [23:20] entry_index, [27:24] entry_next_state, [29:28] entry_action
	input  logic [31:0]        s_axis_tdata,
	// [1:0] mode
	input  logic [1:0]         s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [1:0] action, [5:2] new_state, [6] status
	output logic [7:0]         m_axis_tdata
);

	mode_t    in_mode;
	inputs_t  in_sense;
	state_t   in_target;
	inputs_t  in_mask;
	tbl_idx_t in_eidx;
	state_t   in_enext;
	action_t  in_eact;

	logic     s_accept;
	logic     s1_adv;
	logic     valid_s1;
	mode_t    mode_s1;
	logic     status_s1;
	state_t   state_q;
	state_t   start_state;
	state_t   cur_state;
	state_t   next_state_c;
	action_t  action_c;
	logic     refuse;
	tbl_idx_t gather_idx;
	entry_t   rd_entry;
	mask_wr_t mask_wr;
	tbl_wr_t  tbl_wr;
	tbl_rd_t  tbl_rd;

	logic     out_valid_q;
	action_t  out_action_q;
	state_t   out_state_q;
	logic     out_status_q;

	assign in_mode   = mode_t'(s_axis_tuser);
	assign in_sense  = s_axis_tdata[7:0];
	assign in_target = s_axis_tdata[11:8];
	assign in_mask   = s_axis_tdata[19:12];
	assign in_eidx   = s_axis_tdata[23:20];
	assign in_enext  = s_axis_tdata[27:24];
	assign in_eact   = s_axis_tdata[29:28];

	assign s1_adv        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_comb begin
		next_state_c = state_q;
		action_c     = '0;
		case (mode_s1)
			MODE_STEP: begin
				next_state_c = rd_entry.next;
				action_c     = rd_entry.act;
			end
			MODE_RESTART: next_state_c = start_state;
			default:      next_state_c = state_q;
		endcase
	end

	// the item in stage 1 has not yet committed its state
	assign cur_state = valid_s1 ? next_state_c : state_q;

	assign mask_wr.req    = s_accept && (in_mode == MODE_MASK);
	assign mask_wr.target = in_target;
	assign mask_wr.mask   = in_mask;

	assign tbl_wr.we        = s_accept && (in_mode == MODE_ENTRY);
	assign tbl_wr.addr      = {in_target, in_eidx};
	assign tbl_wr.data.next = in_enext;
	assign tbl_wr.data.act  = in_eact;

	assign tbl_rd.re   = s_accept && (in_mode == MODE_STEP);
	assign tbl_rd.addr = {cur_state, gather_idx};

	mimf_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start_state (start_state)
	);

	mimf_mask_gather u_gather (
		.clk      (clk),
		.arst_n   (arst_n),
		.mask_wr  (mask_wr),
		.refuse   (refuse),
		.rd_state (cur_state),
		.sense    (in_sense),
		.idx      (gather_idx)
	);

	mimf_table_ram u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				state_q     <= next_state_c;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			mode_s1   <= in_mode;
			status_s1 <= (in_mode == MODE_MASK) && refuse;
		end
		if (s1_adv) begin
			out_action_q <= action_c;
			out_state_q  <= next_state_c;
			out_status_q <= status_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_status_q, out_state_q, out_action_q};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !s1_adv)
		else $error("result register overwritten while stalled");

	a_action_step_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && mode_s1 != MODE_STEP |-> action_c == '0)
		else $error("non-zero action for a non-step item");

	a_status_mask_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && status_s1 |-> mode_s1 == MODE_MASK)
		else $error("refusal status on an item that is not a mask write");

	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && mode_s1 == MODE_RESTART |=> state_q == $past(start_state))
		else $error("restart did not load the start state");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && (mode_s1 == MODE_MASK || mode_s1 == MODE_ENTRY) |=> $stable(state_q))
		else $error("state changed on a store write");

endmodule

@@ sim/tb_masked_input_mealy_fsm_top.sv @@
// Self-checking bench for masked_input_mealy_fsm_top: random and directed items on the stream port,
// start-state writes over APB, results predicted by a scoreboard class kept in step with the block.
// Depends on mimf_pkg and the design sources only.
module tb_masked_input_mealy_fsm_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mimf_pkg::*;

	localparam int ROWS         = 1 << TABLE_COLUMNS;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_ITEMS  = 200;

	typedef struct {
		mode_t    mode;
		inputs_t  sense;
		state_t   target;
		inputs_t  maskv;
		tbl_idx_t eidx;
		state_t   enext;
		action_t  eact;
	} fsm_item_t;

	typedef struct {
		action_t act;
		state_t  st;
		logic    status;
	} fsm_result_t;

	class mealy_scoreboard;
		state_t      start_st;
		state_t      cur_st;
		inputs_t     masks[NUM_STATES];
		entry_t      rows[NUM_STATES*ROWS];
		bit          written[NUM_STATES*ROWS];
		fsm_result_t predicted_results[$];
		int          errors;

		function new();
			start_st = '0;
			cur_st   = '0;
			errors   = 0;
			foreach (masks[i]) masks[i] = '0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		// selected sense bits, lowest selected input into index bit 0
		function tbl_idx_t gather(inputs_t m, inputs_t s);
			tbl_idx_t idx = '0;
			int pos = 0;
			for (int i = 0; i < NUM_INPUTS; i++) begin
				if (m[i]) begin
					if (pos < TABLE_COLUMNS && s[i])
						idx[pos] = 1'b1;
					pos++;
				end
			end
			return idx;
		endfunction

		function int row_of(inputs_t s);
			return int'(cur_st) * ROWS + int'(gather(masks[cur_st], s));
		endfunction

		function void note_input(fsm_item_t it);
			fsm_result_t r;
			r.act    = '0;
			r.status = 1'b0;
			case (it.mode)
				MODE_STEP: begin
					r.act  = rows[row_of(it.sense)].act;
					cur_st = rows[row_of(it.sense)].next;
				end
				MODE_RESTART: cur_st = start_st;
				MODE_MASK: begin
					if ($countones(it.maskv) > TABLE_COLUMNS)
						r.status = 1'b1;
					else
						masks[it.target] = it.maskv;
				end
				default: begin
					rows[int'(it.target) * ROWS + int'(it.eidx)].next = it.enext;
					rows[int'(it.target) * ROWS + int'(it.eidx)].act  = it.eact;
					written[int'(it.target) * ROWS + int'(it.eidx)]  = 1'b1;
				end
			endcase
			r.st = cur_st;
			predicted_results.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(fsm_result_t got);
			fsm_result_t want;
			if (predicted_results.size() == 0) begin
				report("result item with nothing expected");
			end else begin
				want = predicted_results.pop_front();
				if (got.act !== want.act)
					report($sformatf("action %0d, expected %0d", got.act, want.act));
				if (got.st !== want.st)
					report($sformatf("new_state %0d, expected %0d", got.st, want.st));
				if (got.status !== want.status)
					report($sformatf("status %0b, expected %0b", got.status, want.status));
			end
		endtask

		function int pending();
			return predicted_results.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [31:0]        s_axis_tdata = '0;
	logic [1:0]         s_axis_tuser = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [7:0]         m_axis_tdata;

	mealy_scoreboard sb = new();
	bit  calm = 1'b0;
	int  stall_left = 0;
	int  cycles = 0;

	masked_input_mealy_fsm_top dut (.*);

	always #2 clk = ~clk;

	// mostly short gaps, a few long ones; none while calm
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result('{act: m_axis_tdata[1:0], st: m_axis_tdata[5:2],
				status: m_axis_tdata[6]});
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			m_axis_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("** masked_input_mealy_fsm_top: FAILED **");
			$finish;
		end
	end

	function fsm_item_t rand_item();
		fsm_item_t it;
		it.mode   = mode_t'($urandom_range(0, 3));
		it.sense  = inputs_t'($urandom);
		it.target = state_t'($urandom);
		it.maskv  = inputs_t'($urandom);
		it.eidx   = tbl_idx_t'($urandom);
		it.enext  = state_t'($urandom);
		it.eact   = action_t'($urandom);
		return it;
	endfunction

	// called just after a rising edge; returns just after the accepting edge
	task push_item(fsm_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.mode;
		s_axis_tdata  <= {2'b00, it.eact, it.enext, it.eidx, it.maskv, it.target, it.sense};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(it);
	endtask

	task do_entry(state_t t, tbl_idx_t i, state_t n, action_t a);
		fsm_item_t it;
		it = rand_item();
		it.mode   = MODE_ENTRY;
		it.target = t;
		it.eidx   = i;
		it.enext  = n;
		it.eact   = a;
		push_item(it);
	endtask

	// fills the row about to be read first if it has never been written
	task do_step(inputs_t s);
		fsm_item_t it;
		int row;
		row = sb.row_of(s);
		if (!sb.written[row])
			do_entry(state_t'(row / ROWS), tbl_idx_t'(row % ROWS), state_t'($urandom),
				action_t'($urandom));
		it = rand_item();
		it.mode  = MODE_STEP;
		it.sense = s;
		push_item(it);
	endtask

	task do_mask(state_t t, inputs_t m);
		fsm_item_t it;
		it = rand_item();
		it.mode   = MODE_MASK;
		it.target = t;
		it.maskv  = m;
		push_item(it);
	endtask

	task do_restart();
		fsm_item_t it;
		it = rand_item();
		it.mode = MODE_RESTART;
		push_item(it);
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write then read back; the write lands at the access edge
	task set_start_state(state_t v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_START_STATE;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.start_st = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(v))
			sb.report($sformatf("start_state read %0h, expected %0h", prdata, v));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task random_phase(int n);
		inputs_t m;
		int r;
		do_restart();
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				do_step(inputs_t'($urandom));
			end else if (r < 65) begin
				do_restart();
			end else if (r < 80) begin
				m = inputs_t'($urandom);
				if ($urandom_range(0, 3) != 0)
					while ($countones(m) > TABLE_COLUMNS) m[$urandom_range(0, NUM_INPUTS-1)] = 1'b0;
				do_mask(state_t'($urandom), m);
			end else begin
				do_entry(state_t'($urandom), tbl_idx_t'($urandom), state_t'($urandom),
					action_t'($urandom));
			end
		end
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_start_state(state_t'(0));
		// directed: empty masks, extreme masks, refused masks, extreme states and actions
		do_entry(4'd0, 4'd0, 4'd15, 2'd3);
		do_step(8'hFF);
		do_mask(4'd15, 8'hF0);
		do_mask(4'd15, 8'h1F);
		do_mask(4'd15, 8'hFF);
		do_entry(4'd15, 4'd15, 4'd0, 2'd0);
		do_step(8'hF0);
		do_mask(4'd0, 8'h81);
		do_step(8'h80);
		do_step(8'h01);
		do_restart();
		do_mask(4'd0, 8'h55);
		do_step(8'hAA);
		do_step(8'h55);
		do_mask(4'd0, 8'h00);
		do_step(8'h00);
		do_restart();
		do_mask(4'd7, 8'h0F);
		do_entry(4'd0, 4'd0, 4'd7, 2'd2);
		do_step(8'hFF);
		do_step(8'h0F);
		drain();
		random_phase(PHASE_ITEMS);

		set_start_state(state_t'(15));
		calm = 1'b1;
		random_phase(PHASE_ITEMS);
		calm = 1'b0;

		set_start_state(state_t'($urandom_range(1, 14)));
		random_phase(PHASE_ITEMS);

		set_start_state(state_t'(15));
		random_phase(PHASE_ITEMS);

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** masked_input_mealy_fsm_top: PASSED **");
		end else begin
			$display("** masked_input_mealy_fsm_top: FAILED **");
		end
		$finish;
	end

endmodule

@@ masked_input_mealy_fsm_top.f @@
design/mimf_pkg.sv
design/mimf_apb_regs.sv
design/mimf_mask_gather.sv
design/mimf_table_ram.sv
design/masked_input_mealy_fsm_top.sv
sim/tb_masked_input_mealy_fsm_top.sv
